[rtl/core/ihc_pkg.sv]
// Package for the IPv4 ingress header check: request and response payload
// types, verdict codes and header constants. No dependencies.
package ihc_pkg;

   localparam logic [2:0] VERDICT_PASS     = 3'd0;
   localparam logic [2:0] VERDICT_PUNT     = 3'd1;
   localparam logic [2:0] VERDICT_OTHER    = 3'd2;
   localparam logic [2:0] VERDICT_HDRERR   = 3'd3;
   localparam logic [2:0] VERDICT_CSUMERR  = 3'd4;
   localparam logic [2:0] VERDICT_TRUNC    = 3'd5;

   localparam logic [7:0]  PROTO_OSPF      = 8'd89;
   localparam logic [15:0] SUM_GOOD        = 16'hFFFF;
   localparam logic [3:0]  IP_VERSION      = 4'd4;
   localparam logic [15:0] MIN_HDR_BYTES   = 16'd20;
   localparam logic [3:0]  MIN_IHL         = 4'd5;
   localparam logic [4:0]  IDX_TOTAL_LEN   = 5'd1;
   localparam logic [4:0]  IDX_PROTOCOL    = 5'd4;

   typedef struct packed {
      logic [15:0] header_word;
      logic        first_word;
      logic [15:0] packet_bytes;
      logic        for_other_host;
      logic        port_present;
      logic        checksum_offloaded;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [5:0]  header_bytes;
      logic [15:0] trim_bytes;
      logic [7:0]  protocol;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

[rtl/core/ipv4_ingress_header_check_top.sv]
// The block takes one 16-bit packet word per cycle, unless stalled, on the
// request channel and returns at most one verdict per packet, registered
// from the word that decides it: the first word for early drops, else the
// last header word (2*IHL-1). The ones' complement header sum and the length
// checks are one registered pass, so a request is accepted every cycle; a
// two-entry output buffer lets requests flow while a verdict waits, and
// stall is raised only when both entries are full. The punt protocol
// register resets to 89 (OSPF). Top level; depends on ihc_pkg and ihc_parse.
module ipv4_ingress_header_check_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ihc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ihc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   logic [7:0]          punt_ff;
   logic                rsp_valid_ff;
   ihc_pkg::rsp_type    rsp_ff;
   logic                skid_valid_ff;
   ihc_pkg::rsp_type    skid_ff;
   logic                req_accept;
   logic                rsp_accept;
   ihc_pkg::result_type result;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   ihc_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req           (req_data),
      .punt_protocol (punt_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         punt_ff <= ihc_pkg::PROTO_OSPF;
      end else if (csr_valid && csr_ready) begin
         punt_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_accept) begin
            rsp_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_accept) begin
         rsp_valid_ff <= result.valid;
         rsp_ff       <= result.data;
      end else if (result.valid) begin
         skid_ff       <= result.data;
         skid_valid_ff <= 1'b1;
      end
   end

`ifndef SYNTH
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("Skid entry held without a pending response.");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.verdict <= ihc_pkg::VERDICT_TRUNC)
      else $error("Response carries an undefined verdict code.");

   a_other_host_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.verdict == ihc_pkg::VERDICT_OTHER) |->
      (rsp_ff.header_bytes == 6'd0 && rsp_ff.protocol == 8'd0))
      else $error("Not-for-host response carries header fields.");

   a_trim_only_on_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.trim_bytes != 16'd0) |->
      (rsp_ff.verdict == ihc_pkg::VERDICT_PASS || rsp_ff.verdict == ihc_pkg::VERDICT_PUNT))
      else $error("Trim amount reported on a failing verdict.");
`endif

endmodule

[rtl/core/ihc_parse.sv]
// Header parser for the IPv4 ingress header check: per-packet state and the
// verdict logic for each accepted request. Depends on ihc_pkg.
module ihc_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_accept,
   input  ihc_pkg::req_type   req,
   input  logic [7:0]         punt_protocol,
   output ihc_pkg::result_type result
);

   logic [4:0]  word_index_ff, word_index_in;
   logic        in_header_ff, in_header_in;
   logic [3:0]  ihl_words_ff, ihl_words_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [15:0] packet_length_ff, packet_length_in;
   logic [7:0]  proto_ff, proto_in;
   logic        skip_ff, skip_in;

   logic [16:0] sum_full;
   logic [15:0] sum_fold;
   logic [15:0] tot_cur;
   logic [7:0]  proto_cur;
   logic [5:0]  hb_first;
   logic [5:0]  hb_stored;
   logic [5:0]  idx_next;
   logic [4:0]  last_idx;

   assign sum_full  = {1'b0, sum_ff} + {1'b0, req.header_word};
   assign sum_fold  = sum_full[15:0] + {15'd0, sum_full[16]};
   assign tot_cur   = (word_index_ff == ihc_pkg::IDX_TOTAL_LEN) ? req.header_word
                                                                : total_length_ff;
   assign proto_cur = (word_index_ff == ihc_pkg::IDX_PROTOCOL) ? req.header_word[7:0]
                                                               : proto_ff;
   assign hb_first  = {req.header_word[11:8], 2'b00};
   assign hb_stored = {ihl_words_ff, 2'b00};
   assign idx_next  = {1'b0, word_index_ff} + 6'd1;
   assign last_idx  = {ihl_words_ff, 1'b0};

   always_comb begin
      word_index_in    = word_index_ff;
      in_header_in     = in_header_ff;
      ihl_words_in     = ihl_words_ff;
      sum_in           = sum_ff;
      total_length_in  = total_length_ff;
      packet_length_in = packet_length_ff;
      proto_in         = proto_ff;
      skip_in          = skip_ff;
      result           = '0;
      if (req_accept) begin
         if (req.first_word) begin
            packet_length_in = req.packet_bytes;
            skip_in          = req.checksum_offloaded;
            in_header_in     = 1'b0;
            word_index_in    = '0;
            sum_in           = '0;
            total_length_in  = '0;
            proto_in         = '0;
            ihl_words_in     = '0;
            if (req.for_other_host || !req.port_present) begin
               result.valid        = 1'b1;
               result.data.verdict = ihc_pkg::VERDICT_OTHER;
            end else if (req.packet_bytes < ihc_pkg::MIN_HDR_BYTES) begin
               result.valid        = 1'b1;
               result.data.verdict = ihc_pkg::VERDICT_HDRERR;
            end else begin
               ihl_words_in = req.header_word[11:8];
               if (req.header_word[15:12] != ihc_pkg::IP_VERSION ||
                   req.header_word[11:8] < ihc_pkg::MIN_IHL ||
                   req.packet_bytes < {10'd0, hb_first}) begin
                  result.valid             = 1'b1;
                  result.data.verdict      = ihc_pkg::VERDICT_HDRERR;
                  result.data.header_bytes = hb_first;
               end else begin
                  sum_in        = req.header_word;
                  word_index_in = 5'd1;
                  in_header_in  = 1'b1;
               end
            end
         end else if (in_header_ff) begin
            sum_in          = sum_fold;
            total_length_in = tot_cur;
            proto_in        = proto_cur;
            if (idx_next >= {1'b0, last_idx}) begin
               in_header_in             = 1'b0;
               result.valid             = 1'b1;
               result.data.header_bytes = hb_stored;
               result.data.protocol     = proto_cur;
               if (!skip_ff && sum_fold != ihc_pkg::SUM_GOOD) begin
                  result.data.verdict = ihc_pkg::VERDICT_CSUMERR;
               end else if (packet_length_ff < tot_cur) begin
                  result.data.verdict = ihc_pkg::VERDICT_TRUNC;
               end else if (tot_cur < {10'd0, hb_stored}) begin
                  result.data.verdict = ihc_pkg::VERDICT_HDRERR;
               end else begin
                  result.data.verdict    = (proto_cur == punt_protocol) ?
                                           ihc_pkg::VERDICT_PUNT : ihc_pkg::VERDICT_PASS;
                  result.data.trim_bytes = packet_length_ff - tot_cur;
               end
            end else begin
               word_index_in = idx_next[4:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff    <= '0;
         in_header_ff     <= 1'b0;
         ihl_words_ff     <= '0;
         sum_ff           <= '0;
         total_length_ff  <= '0;
         packet_length_ff <= '0;
         proto_ff         <= '0;
         skip_ff          <= 1'b0;
      end else begin
         word_index_ff    <= word_index_in;
         in_header_ff     <= in_header_in;
         ihl_words_ff     <= ihl_words_in;
         sum_ff           <= sum_in;
         total_length_ff  <= total_length_in;
         packet_length_ff <= packet_length_in;
         proto_ff         <= proto_in;
         skip_ff          <= skip_in;
      end
   end

endmodule

[tb/testbench.sv]
// Self-checking testbench for ipv4_ingress_header_check_top: streams packet words,
// predicts every verdict in a local model of the header check and compares the responses.
// Depends on ihc_pkg and the RTL of the block.
module testbench;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_REPORTS = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_WORDS = 750;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ihc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ihc_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_data = '0;

   logic [7:0] punt_proto = ihc_pkg::PROTO_OSPF;
   logic [4:0] word_idx = '0;
   logic collecting = 1'b0;
   logic [3:0] ihl_field = '0;
   logic [15:0] hdr_sum = '0;
   logic [15:0] tot_len = '0;
   logic [15:0] pkt_len = '0;
   logic [7:0] proto_byte = '0;
   logic csum_skip = 1'b0;

   ihc_pkg::rsp_type verdict_q[$];
   logic [15:0] hdr_buf[$];
   int live_words = 0;
   int fault_count = 0;
   int cycle_count = 0;
   bit no_gaps = 1'b0;
   int stall_left = 0;
   bit stall_level = 1'b0;

   ipv4_ingress_header_check_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      int r;
      if (stall_left == 0) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            stall_level = 1'b0;
            stall_left = $urandom_range(1, 8);
         end else if (r < 80) begin
            stall_level = 1'b1;
            stall_left = $urandom_range(1, 3);
         end else if (r < 90) begin
            stall_level = 1'b1;
            stall_left = $urandom_range(10, 40);
         end else begin
            stall_level = 1'b0;
            stall_left = $urandom_range(50, 200);
         end
      end
      stall_left = stall_left - 1;
      rsp_stall <= stall_level;
   end

   always @(posedge clock) begin
      ihc_pkg::rsp_type exp_rsp;
      cycle_count = cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            fault_count = fault_count + 1;
            if (fault_count <= MAX_REPORTS)
               $display("cycle %0d: verdict %0d arrived with no request pending",
                        cycle_count, rsp_data.verdict);
         end else begin
            exp_rsp = verdict_q.pop_front();
            if (rsp_data.verdict !== exp_rsp.verdict
                || rsp_data.header_bytes !== exp_rsp.header_bytes
                || rsp_data.trim_bytes !== exp_rsp.trim_bytes
                || rsp_data.protocol !== exp_rsp.protocol) begin
               fault_count = fault_count + 1;
               if (fault_count <= MAX_REPORTS)
                  $display({"cycle %0d: verdict %0d/%0d header_bytes %0d/%0d ",
                            "trim_bytes %0d/%0d protocol %0d/%0d (expected/actual)"},
                           cycle_count, exp_rsp.verdict, rsp_data.verdict,
                           exp_rsp.header_bytes, rsp_data.header_bytes,
                           exp_rsp.trim_bytes, rsp_data.trim_bytes,
                           exp_rsp.protocol, rsp_data.protocol);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** ipv4_ingress_header_check_top: FAILED **");
         $finish;
      end
   end

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // Returns 0 for a word that the block ignores.
   function bit predict_word(input ihc_pkg::req_type r);
      ihc_pkg::rsp_type res;
      int hb;
      bit done;
      res = '0;
      done = 1'b0;
      predict_word = 1'b1;
      if (r.first_word) begin
         pkt_len = r.packet_bytes;
         csum_skip = r.checksum_offloaded;
         collecting = 1'b0;
         word_idx = '0;
         hdr_sum = '0;
         tot_len = '0;
         proto_byte = '0;
         ihl_field = '0;
         if (r.for_other_host || !r.port_present) begin
            res.verdict = ihc_pkg::VERDICT_OTHER;
            done = 1'b1;
         end else if (pkt_len < ihc_pkg::MIN_HDR_BYTES) begin
            res.verdict = ihc_pkg::VERDICT_HDRERR;
            done = 1'b1;
         end else begin
            ihl_field = r.header_word[11:8];
            hb = int'(ihl_field) * 4;
            res.header_bytes = {ihl_field, 2'b00};
            if (r.header_word[15:12] != ihc_pkg::IP_VERSION
                || ihl_field < ihc_pkg::MIN_IHL
                || int'(pkt_len) < hb) begin
               res.verdict = ihc_pkg::VERDICT_HDRERR;
               done = 1'b1;
            end else begin
               hdr_sum = ones_add(16'd0, r.header_word);
               word_idx = 5'd1;
               collecting = 1'b1;
            end
         end
      end else if (!collecting) begin
         predict_word = 1'b0;
      end else begin
         hdr_sum = ones_add(hdr_sum, r.header_word);
         if (word_idx == ihc_pkg::IDX_TOTAL_LEN)
            tot_len = r.header_word;
         if (word_idx == ihc_pkg::IDX_PROTOCOL)
            proto_byte = r.header_word[7:0];
         if (int'(word_idx) + 1 >= 2 * int'(ihl_field)) begin
            hb = int'(ihl_field) * 4;
            collecting = 1'b0;
            done = 1'b1;
            res.header_bytes = {ihl_field, 2'b00};
            res.protocol = proto_byte;
            if (!csum_skip && hdr_sum != ihc_pkg::SUM_GOOD)
               res.verdict = ihc_pkg::VERDICT_CSUMERR;
            else if (pkt_len < tot_len)
               res.verdict = ihc_pkg::VERDICT_TRUNC;
            else if (int'(tot_len) < hb)
               res.verdict = ihc_pkg::VERDICT_HDRERR;
            else begin
               res.verdict = (proto_byte == punt_proto) ? ihc_pkg::VERDICT_PUNT
                                                        : ihc_pkg::VERDICT_PASS;
               res.trim_bytes = pkt_len - tot_len;
            end
         end else begin
            word_idx = word_idx + 5'd1;
         end
      end
      if (done)
         verdict_q.push_back(res);
   endfunction

   function ihc_pkg::req_type make_req(input bit is_first, input logic [15:0] w,
                                       input logic [15:0] plen, input bit other,
                                       input bit port, input bit offl);
      ihc_pkg::req_type r;
      r.header_word = w;
      r.first_word = is_first;
      if (is_first) begin
         r.packet_bytes = plen;
         r.for_other_host = other;
         r.port_present = port;
         r.checksum_offloaded = offl;
      end else begin
         r.packet_bytes = 16'($urandom);
         r.for_other_host = 1'($urandom);
         r.port_present = 1'($urandom);
         r.checksum_offloaded = 1'($urandom);
      end
      return r;
   endfunction

   function int pick_gap();
      int r;
      if (no_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Fills the header buffer with a well-formed header whose checksum is correct.
   function void build_header(input int ihl, input int tot, input logic [7:0] proto);
      logic [15:0] sum;
      hdr_buf.delete();
      hdr_buf.push_back({ihc_pkg::IP_VERSION, 4'(ihl), 8'($urandom)});
      hdr_buf.push_back(16'(tot));
      hdr_buf.push_back(16'($urandom));
      hdr_buf.push_back(16'($urandom));
      hdr_buf.push_back({8'($urandom), proto});
      hdr_buf.push_back(16'h0000);
      for (int i = 6; i < 2 * ihl; i++)
         hdr_buf.push_back(16'($urandom));
      sum = '0;
      foreach (hdr_buf[i])
         sum = ones_add(sum, hdr_buf[i]);
      hdr_buf[5] = ~sum;
   endfunction

   task send_word(input ihc_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_word(r))
         live_words = live_words + 1;
   endtask

   task send_packet(input logic [15:0] plen, input bit other, input bit port, input bit offl,
                    input int ncut, input int ntail);
      for (int i = 0; i < ncut; i++)
         send_word(make_req(i == 0, hdr_buf[i], plen, other, port, offl));
      for (int i = 0; i < ntail; i++)
         send_word(make_req(1'b0, 16'($urandom), plen, other, port, offl));
   endtask

   task drain_verdicts();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_punt(input logic [7:0] v);
      drain_verdicts();
      csr_data <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      punt_proto = v;
   endtask

   task test_early_drops();
      send_word(make_req(1'b1, 16'h4500, 16'd100, 1'b1, 1'b1, 1'b0));
      send_word(make_req(1'b1, 16'h4500, 16'd100, 1'b0, 1'b0, 1'b0));
      send_word(make_req(1'b1, 16'h4500, 16'd19, 1'b0, 1'b1, 1'b0));
      send_word(make_req(1'b1, 16'h4500, 16'd0, 1'b0, 1'b1, 1'b1));
      send_word(make_req(1'b1, 16'h6500, 16'd100, 1'b0, 1'b1, 1'b0));
      send_word(make_req(1'b1, 16'h4400, 16'd100, 1'b0, 1'b1, 1'b0));
      send_word(make_req(1'b1, 16'h4F00, 16'd59, 1'b0, 1'b1, 1'b0));
      send_word(make_req(1'b1, 16'h0000, 16'd100, 1'b0, 1'b1, 1'b0));
      send_word(make_req(1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0));
   endtask

   task test_header_checks();
      build_header(5, 46, 8'd6);
      send_packet(16'd50, 1'b0, 1'b1, 1'b0, 10, 0);
      build_header(5, 40, 8'd17);
      hdr_buf[7] = hdr_buf[7] ^ 16'h8000;
      send_packet(16'd40, 1'b0, 1'b1, 1'b0, 10, 0);
      hdr_buf.delete();
      hdr_buf.push_back(16'h4500);
      repeat (9) hdr_buf.push_back(16'h0000);
      send_packet(16'd40, 1'b0, 1'b1, 1'b0, 10, 0);
      send_packet(16'd40, 1'b0, 1'b1, 1'b1, 10, 0);
   endtask

   task test_stream_breaks();
      send_word(make_req(1'b0, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0));
      build_header(5, 44, 8'd1);
      send_packet(16'd44, 1'b0, 1'b1, 1'b0, 4, 0);
      send_packet(16'd44, 1'b0, 1'b1, 1'b0, 10, 2);
   endtask

   task test_punt_register();
      write_punt(8'd0);
      build_header(5, 20, 8'd0);
      send_packet(16'd20, 1'b0, 1'b1, 1'b0, 10, 0);
      write_punt(8'd255);
      build_header(15, 60, 8'd255);
      send_packet(16'hFFFF, 1'b0, 1'b1, 1'b0, 30, 0);
      write_punt(8'($urandom));
      build_header(6, 30, punt_proto);
      send_packet(16'd31, 1'b0, 1'b1, 1'b0, 12, 0);
      write_punt(ihc_pkg::PROTO_OSPF);
      build_header(5, 40, ihc_pkg::PROTO_OSPF);
      send_packet(16'd40, 1'b0, 1'b1, 1'b0, 10, 0);
      build_header(5, 40, 8'd6);
      send_packet(16'd48, 1'b0, 1'b1, 1'b0, 10, 0);
   endtask

   task random_packet();
      int kind, pick, ihl, hb, tot, plen, ncut, ntail, idx;
      logic [7:0] proto;
      bit other, port, offl;
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      ihl = (pick < 80) ? $urandom_range(5, 6) : (pick < 95) ? $urandom_range(7, 10)
                                                              : $urandom_range(11, 15);
      hb = ihl * 4;
      tot = hb + $urandom_range(0, 60);
      plen = tot + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      proto = ($urandom_range(0, 3) == 0) ? punt_proto : 8'($urandom);
      other = 1'b0;
      port = 1'b1;
      offl = ($urandom_range(0, 9) == 0);
      ncut = 2 * ihl;
      ntail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      if (kind < 5) begin
         repeat ($urandom_range(1, 3))
            send_word(make_req(1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                               1'($urandom), 1'($urandom)));
      end
      if (kind >= 95) begin
         plen = $urandom_range(hb, 65535);
         tot = $urandom_range(hb, plen);
      end else if (kind >= 90) begin
         tot = plen + $urandom_range(1, 200);
      end else if (kind >= 86) begin
         tot = $urandom_range(0, hb - 1);
      end else if (kind >= 74 && kind < 78) begin
         plen = $urandom_range(0, hb - 1);
      end
      build_header(ihl, tot, proto);
      if (kind >= 60 && kind < 70) begin
         idx = $urandom_range(1, 2 * ihl - 1);
         hdr_buf[idx] = hdr_buf[idx] ^ (16'd1 << $urandom_range(0, 15));
         if (kind >= 66)
            offl = 1'b1;
      end else if (kind >= 70 && kind < 74) begin
         other = 1'($urandom);
         port = other ? 1'($urandom) : 1'b0;
      end else if (kind >= 78 && kind < 82) begin
         if ($urandom_range(0, 1) == 0)
            hdr_buf[0][15:12] = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                                           : 4'($urandom_range(5, 15));
         else
            hdr_buf[0][11:8] = 4'($urandom_range(0, 4));
      end else if (kind >= 82 && kind < 86) begin
         ncut = $urandom_range(1, 2 * ihl - 1);
      end
      send_packet(16'(plen), other, port, offl, ncut, ntail);
   endtask

   task test_random();
      int start_words, next_pause;
      logic [7:0] v;
      start_words = live_words;
      next_pause = 300;
      while (live_words - start_words < RANDOM_WORDS) begin
         if ($urandom_range(0, 19) == 0)
            no_gaps = !no_gaps;
         random_packet();
         if (live_words - start_words >= next_pause) begin
            next_pause = next_pause + 300;
            case ($urandom_range(0, 3))
               0: v = 8'd0;
               1: v = 8'd255;
               2: v = ihc_pkg::PROTO_OSPF;
               default: v = 8'($urandom);
            endcase
            write_punt(v);
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_early_drops();
      test_header_checks();
      test_stream_breaks();
      test_punt_register();
      test_random();
      drain_verdicts();
      if (fault_count == 0)
         $display("** ipv4_ingress_header_check_top: PASSED **");
      else
         $display("** ipv4_ingress_header_check_top: FAILED **");
      $finish;
   end

endmodule

[ipv4_ingress_header_check_top.f]
rtl/core/ihc_pkg.sv
rtl/core/ihc_parse.sv
rtl/core/ipv4_ingress_header_check_top.sv
tb/testbench.sv
